[hw/rtl/mfv_pkg.sv]
`timescale 1ns / 1ps

package mfv_pkg;

   localparam int MaxFrameDefault = 256;
   localparam int MinFrameDefault = 8;

   localparam int ByteW   = 8;
   localparam int ReasonW = 3;
   localparam int LenW    = 9;
   localparam int CrcW    = 16;

   localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
   localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

   localparam logic [ByteW-1:0] AddressReset = 8'h01;

   localparam logic [ByteW-1:0] CharColon = 8'h3A;
   localparam logic [ByteW-1:0] CharCr    = 8'h0D;
   localparam logic [ByteW-1:0] CharLf    = 8'h0A;

   // ASCII frame layout: colon in front, CR LF behind, at least three hex-encoded bytes.
   localparam int AsciiMinLen   = 9;
   localparam int AsciiOverhead = 3;
   localparam int HexMinLen     = 4;
   localparam int HexStartCount = 3;

   localparam logic [ReasonW-1:0] ReasonOk        = 3'd0;
   localparam logic [ReasonW-1:0] ReasonShort     = 3'd1;
   localparam logic [ReasonW-1:0] ReasonStructure = 3'd2;
   localparam logic [ReasonW-1:0] ReasonBadHex    = 3'd3;
   localparam logic [ReasonW-1:0] ReasonAddress   = 3'd4;
   localparam logic [ReasonW-1:0] ReasonLrc       = 3'd5;
   localparam logic [ReasonW-1:0] ReasonCrc       = 3'd6;

   typedef struct packed {
      logic               last;
      logic               accepted;
      logic [ReasonW-1:0] reason;
      logic               is_ascii;
      logic [LenW-1:0]    length;
   } verdict_type;

   function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
      for (int k = 0; k < ByteW; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Upper-case hex digit to nibble; the top bit flags a character that is no digit.
   function automatic logic [4:0] hex_nibble(input logic [ByteW-1:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c[3:0] + 4'd9)};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

endpackage

[hw/rtl/modbus_frame_validator.sv]
`timescale 1ns / 1ps

// Modbus frame checker. Bytes arrive one item at a time with a mark on the last
// byte before the line falls silent; a frame also closes by force at MAX_FRAME bytes.
// Every closed frame yields one verdict item: accepted, a reason code (ok, short,
// ASCII structure, bad hex, address, LRC, CRC), the ASCII flag and the length in
// bytes (low nine bits). A frame opening with a colon is checked as ASCII with LRC,
// any other as RTU with CRC16. One byte is taken every cycle while no closing byte is held.
// A byte waits in the input register, and the byte-wide CRC and hex decode after it
// feed the result register, which drives the verdict outputs. While a verdict is
// stalled at the output, bytes that close no frame still move on, and only a closing
// byte holds the input until the verdict has gone. The user is to write the station
// address through the csr_ channel only while no frame is in flight; the block itself
// does not enforce it.
module modbus_frame_validator #(
   parameter int MAX_FRAME = mfv_pkg::MaxFrameDefault,
   parameter int MIN_FRAME = mfv_pkg::MinFrameDefault
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mfv_pkg::ByteW-1:0]     req_data_byte,
   input  logic                          req_end_of_frame,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [mfv_pkg::ReasonW-1:0]   rsp_reason,
   output logic                          rsp_is_ascii,
   output logic [mfv_pkg::LenW-1:0]      rsp_frame_length,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mfv_pkg::ByteW-1:0]     csr_slave_address
);

   logic                         in_valid_ff;
   logic [mfv_pkg::ByteW-1:0]    in_byte_ff;
   logic                         in_eof_ff;
   logic [mfv_pkg::ByteW-1:0]    addr_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   mfv_pkg::verdict_type         rsp_ff;
   mfv_pkg::verdict_type         verdict;
   logic                         out_free;
   logic                         consume;
   logic                         req_take;

   mfv_frame_state #(
      .MAX_FRAME (MAX_FRAME),
      .MIN_FRAME (MIN_FRAME)
   ) u_state (
      .clock         (clock),
      .reset         (reset),
      .step          (consume),
      .data_byte     (in_byte_ff),
      .end_of_frame  (in_eof_ff),
      .slave_address (addr_ff),
      .verdict       (verdict)
   );

   // A byte that closes no frame moves on even while a verdict waits at the output.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && (!verdict.last || out_free);
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid_in = (consume && verdict.last) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= mfv_pkg::AddressReset;
      end else begin
         in_valid_ff  <= req_take || (in_valid_ff && !consume);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            addr_ff <= csr_slave_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_frame;
      end
      if (consume && verdict.last) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_reason       = rsp_ff.reason;
   assign rsp_is_ascii     = rsp_ff.is_ascii;
   assign rsp_frame_length = rsp_ff.length;

   a_verdict_lands: assert property (@(posedge clock) disable iff (reset)
      (consume && verdict.last) |=> rsp_valid_ff)
      else $error("closing byte consumed but no verdict registered");

   a_accept_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.accepted == (rsp_ff.reason == mfv_pkg::ReasonOk)))
      else $error("accepted flag disagrees with reason code");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(consume && verdict.last))
      else $error("waiting verdict overwritten");

endmodule

[hw/rtl/mfv_frame_state.sv]
`timescale 1ns / 1ps

module mfv_frame_state #(
   parameter int MAX_FRAME = mfv_pkg::MaxFrameDefault,
   parameter int MIN_FRAME = mfv_pkg::MinFrameDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [mfv_pkg::ByteW-1:0]     data_byte,
   input  logic                          end_of_frame,
   input  logic [mfv_pkg::ByteW-1:0]     slave_address,
   output mfv_pkg::verdict_type          verdict
);

   localparam int CountW = $clog2(MAX_FRAME + 1);

   logic [CountW-1:0]          cnt_ff, cnt_in;
   logic [mfv_pkg::CrcW-1:0]   crc_ff, crc_in;
   logic                       ascii_ff, ascii_in;
   logic [mfv_pkg::ByteW-1:0]  tail0_ff, tail0_in;
   logic [mfv_pkg::ByteW-1:0]  tail1_ff, tail1_in;
   logic [3:0]                 high_ff, high_in;
   logic                       phase_ff, phase_in;
   logic [mfv_pkg::ByteW-1:0]  addr_ff, addr_in;
   logic                       seen_ff, seen_in;
   logic [mfv_pkg::ByteW-1:0]  lrc_ff, lrc_in;
   logic                       bad_ff, bad_in;

   logic                       first;
   logic                       take;
   logic [4:0]                 nib;
   logic [mfv_pkg::ByteW-1:0]  decoded;
   logic                       last;
   logic [mfv_pkg::ReasonW-1:0] reason;
   logic [CountW+mfv_pkg::LenW-1:0] len_ext;

   always_comb begin
      first    = (cnt_ff == '0);
      take     = !first && ascii_ff && (cnt_ff >= CountW'(mfv_pkg::HexStartCount));
      nib      = mfv_pkg::hex_nibble(tail1_ff);
      decoded  = {high_ff, nib[3:0]};

      ascii_in = first ? (data_byte == mfv_pkg::CharColon) : ascii_ff;
      addr_in  = addr_ff;
      seen_in  = seen_ff;
      high_in  = high_ff;
      phase_in = phase_ff;
      lrc_in   = lrc_ff;
      bad_in   = bad_ff;

      if (first && (data_byte != mfv_pkg::CharColon)) begin
         addr_in = data_byte;
      end

      // A character is decoded once two later bytes have arrived, so CR LF never are.
      if (take) begin
         bad_in = bad_ff | nib[4];
         if (!phase_ff) begin
            high_in  = nib[3:0];
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            lrc_in   = lrc_ff + decoded;
            if (!seen_ff) begin
               addr_in = decoded;
               seen_in = 1'b1;
            end
         end
      end

      crc_in   = mfv_pkg::crc_byte(crc_ff, data_byte);
      tail1_in = tail0_ff;
      tail0_in = data_byte;
      cnt_in   = cnt_ff + 1'b1;
      last     = end_of_frame || (cnt_in == CountW'(MAX_FRAME));

      if (cnt_in < CountW'(MIN_FRAME)) begin
         reason = mfv_pkg::ReasonShort;
      end else if (ascii_in) begin
         if (cnt_in < CountW'(mfv_pkg::AsciiMinLen) || tail1_in != mfv_pkg::CharCr ||
             tail0_in != mfv_pkg::CharLf) begin
            reason = mfv_pkg::ReasonStructure;
         end else if (!cnt_in[0] ||
                      cnt_in < CountW'(mfv_pkg::AsciiOverhead + mfv_pkg::HexMinLen)) begin
            // The hex payload is the length less three, odd exactly when the length is even.
            reason = mfv_pkg::ReasonStructure;
         end else if (bad_in) begin
            reason = mfv_pkg::ReasonBadHex;
         end else if (addr_in != slave_address) begin
            reason = mfv_pkg::ReasonAddress;
         end else if (lrc_in != '0) begin
            reason = mfv_pkg::ReasonLrc;
         end else begin
            reason = mfv_pkg::ReasonOk;
         end
      end else if (addr_in != slave_address) begin
         reason = mfv_pkg::ReasonAddress;
      end else if (crc_in != '0) begin
         reason = mfv_pkg::ReasonCrc;
      end else begin
         reason = mfv_pkg::ReasonOk;
      end

      len_ext          = {{mfv_pkg::LenW{1'b0}}, cnt_in};
      verdict.last     = last;
      verdict.accepted = (reason == mfv_pkg::ReasonOk);
      verdict.reason   = reason;
      verdict.is_ascii = ascii_in;
      verdict.length   = len_ext[mfv_pkg::LenW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         cnt_ff   <= '0;
         crc_ff   <= mfv_pkg::CrcInit;
         ascii_ff <= 1'b0;
         tail0_ff <= '0;
         tail1_ff <= '0;
         high_ff  <= '0;
         phase_ff <= 1'b0;
         addr_ff  <= '0;
         seen_ff  <= 1'b0;
         lrc_ff   <= '0;
         bad_ff   <= 1'b0;
      end else if (step) begin
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         ascii_ff <= ascii_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
         high_ff  <= high_in;
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         seen_ff  <= seen_in;
         lrc_ff   <= lrc_in;
         bad_ff   <= bad_in;
      end
   end

   a_count_below_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CountW'(MAX_FRAME))
      else $error("frame byte count reached the forced end without closing the frame");

   a_rtu_no_hex_state: assert property (@(posedge clock) disable iff (reset)
      !ascii_ff |-> (!phase_ff && !bad_ff && !seen_ff && lrc_ff == '0))
      else $error("hex decoding state moved outside an ASCII frame");

   a_clean_frame_start: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> (crc_ff == mfv_pkg::CrcInit && !ascii_ff && tail0_ff == '0))
      else $error("frame state not cleared at a frame start");

endmodule
